/* sv/tda_pkg.sv */
// Shared types and constants for the time-of-day arithmetic pipeline.
package tda_pkg;

  localparam int unsigned DAY_SECONDS    = 86400;
  localparam int unsigned HOUR_SECONDS   = 3600;
  localparam int unsigned MINUTE_SECONDS = 60;

  // n mod 86400 = ((n >> 7) mod 675) * 128 + (n & 127)
  localparam int unsigned DIV_HI     = 675;
  localparam int unsigned RECIP_675  = 25451658;  // floor(2^34 / 675)
  // c / 3600 = ((c >> 4) * 4661) >> 20 for c < 86400
  localparam int unsigned RECIP_225  = 4661;
  // r / 60 = ((r >> 2) * 1093) >> 14 for r < 3600
  localparam int unsigned RECIP_15   = 1093;

  localparam logic [2:0] MODE_ADD     = 3'd0;
  localparam logic [2:0] MODE_SUB     = 3'd1;
  localparam logic [2:0] MODE_DUR     = 3'd2;
  localparam logic [2:0] MODE_CMP     = 3'd3;
  localparam logic [2:0] MODE_TO_TIME = 3'd4;
  localparam logic [2:0] MODE_TO_SECS = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  a_hour;
    logic [5:0]  a_minute;
    logic [5:0]  a_second;
    logic [4:0]  b_hour;
    logic [5:0]  b_minute;
    logic [5:0]  b_second;
    logic [30:0] n_seconds;
  } cmd_word_t;

  typedef struct packed {
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic [16:0] r_seconds;
    logic        equal;
    logic        less;
    logic        greater;
    logic        a_valid;
  } res_word_t;

  typedef struct packed {
    logic [16:0] r_seconds;
    logic        equal;
    logic        less;
    logic        greater;
    logic        a_valid;
  } side_t;

endpackage

/* sv/tda_modday.sv */
// Three-stage reduction of a 31-bit second count modulo one day.
module tda_modday (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] n,
  output logic [16:0] nmod
);
  import tda_pkg::*;

  logic [23:0] x1;
  logic [6:0]  lo1;
  logic [48:0] p1;
  logic [14:0] q;
  logic [23:0] qm;
  logic [10:0] rem2;
  logic [6:0]  lo2;

  assign q  = p1[48:34];
  assign qm = 24'(q) * 24'(DIV_HI);

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= n[30:7];
      lo1  <= n[6:0];
      p1   <= 49'(n[30:7]) * 49'(RECIP_675);
      rem2 <= 11'(x1 - qm);
      lo2  <= lo1;
      nmod <= {(rem2 >= 11'(DIV_HI)) ? 10'(rem2 - 11'(DIV_HI)) : rem2[9:0], lo2};
    end
  end

endmodule

/* sv/tda_hms.sv */
// Four-stage split of a second count below one day into hour, minute, second.
module tda_hms (
  input  logic        clk,
  input  logic        en,
  input  logic [16:0] c,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);
  import tda_pkg::*;

  logic [16:0] c5;
  logic [25:0] p5;
  logic [4:0]  h6;
  logic [4:0]  h6_reg;
  logic [11:0] rem6;
  logic [19:0] p7;
  logic [11:0] rem7;
  logic [4:0]  h7;
  logic [5:0]  m7;

  assign h6 = p5[24:20];
  assign m7 = p7[19:14];

  always_ff @(posedge clk) begin
    if (en) begin
      c5     <= c;
      p5     <= 26'(c[16:4]) * 26'(RECIP_225);
      h6_reg <= h6;
      rem6   <= 12'(c5 - 17'(h6) * 17'(HOUR_SECONDS));
      p7     <= 20'(rem6[11:2]) * 20'(RECIP_15);
      rem7   <= rem6;
      h7     <= h6_reg;
      hour   <= h7;
      minute <= m7;
      second <= 6'(rem7 - 12'(m7) * 12'(MINUTE_SECONDS));
    end
  end

endmodule

/* sv/time_of_day_arithmetic.sv */
// Top level of the eight-stage time-of-day arithmetic pipeline.
//
//   channel | direction | handshake           | word
//   cmd     | in        | cmd_valid/cmd_stall | cmd_word_t
//   res     | out       | res_valid/res_stall | res_word_t
//
// One word is accepted per cycle while the result is not stalled.
// Depth is set by the reciprocal multiplies for mod 86400, /3600 and /60.
// Reset clears the stage valid bits only.
// A stalled result freezes the whole pipeline; cmd_stall follows it.
module time_of_day_arithmetic (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  tda_pkg::cmd_word_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output tda_pkg::res_word_t res
);
  import tda_pkg::*;

  logic        en;
  logic [7:0]  vld;

  logic [16:0] ra;
  logic [16:0] rb;
  logic [2:0]  s1_mode;
  logic [16:0] s1_ra;
  logic [16:0] s1_rb;
  logic        s1_equal;
  logic        s1_a_ok;

  logic [2:0]  s2_mode;
  logic [16:0] s2_da;
  logic [16:0] s2_db;
  logic        s2_lt;
  logic        s2_gt;
  logic        s2_equal;
  logic        s2_a_ok;

  logic [2:0]  s3_mode;
  logic [16:0] s3_da;
  logic [16:0] s3_db;
  logic        s3_lt;
  logic        s3_gt;
  logic        s3_equal;
  logic        s3_a_ok;

  logic [16:0] nmod;
  logic [17:0] sum_add;
  logic [17:0] sum_sub;
  logic [16:0] c_next;
  logic [16:0] secs_next;
  logic [16:0] s4_c;
  side_t       side_next;
  side_t       side [4:8];

  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  assign en        = !(vld[7] && res_stall);
  assign cmd_stall = !en;
  assign res_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:0], cmd_valid};
    end
  end

  // stage 1: raw second counts
  assign ra = 17'(cmd.a_hour) * 17'(HOUR_SECONDS) + 17'(cmd.a_minute) * 17'(MINUTE_SECONDS)
            + 17'(cmd.a_second);
  assign rb = 17'(cmd.b_hour) * 17'(HOUR_SECONDS) + 17'(cmd.b_minute) * 17'(MINUTE_SECONDS)
            + 17'(cmd.b_second);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode  <= cmd.mode;
      s1_ra    <= ra;
      s1_rb    <= rb;
      s1_equal <= (cmd.a_hour == cmd.b_hour) && (cmd.a_minute == cmd.b_minute)
                  && (cmd.a_second == cmd.b_second);
      s1_a_ok  <= (cmd.a_hour <= 5'd23) && (cmd.a_minute <= 6'd59) && (cmd.a_second <= 6'd59);
    end
  end

  // stage 2: fold into one day, raw compare
  always_ff @(posedge clk) begin
    if (en) begin
      s2_mode  <= s1_mode;
      s2_da    <= (s1_ra >= 17'(DAY_SECONDS)) ? s1_ra - 17'(DAY_SECONDS) : s1_ra;
      s2_db    <= (s1_rb >= 17'(DAY_SECONDS)) ? s1_rb - 17'(DAY_SECONDS) : s1_rb;
      s2_lt    <= s1_ra < s1_rb;
      s2_gt    <= s1_ra > s1_rb;
      s2_equal <= s1_equal;
      s2_a_ok  <= s1_a_ok;
    end
  end

  // stage 3: wait for n mod day
  always_ff @(posedge clk) begin
    if (en) begin
      s3_mode  <= s2_mode;
      s3_da    <= s2_da;
      s3_db    <= s2_db;
      s3_lt    <= s2_lt;
      s3_gt    <= s2_gt;
      s3_equal <= s2_equal;
      s3_a_ok  <= s2_a_ok;
    end
  end

  tda_modday u_modday (
    .clk  (clk),
    .en   (en),
    .n    (cmd.n_seconds),
    .nmod (nmod)
  );

  // stage 4: select operation
  assign sum_add = 18'(s3_da) + 18'(nmod);
  assign sum_sub = 18'(s3_da) + 18'(DAY_SECONDS) - 18'(nmod);

  always_comb begin
    c_next    = '0;
    secs_next = '0;
    case (s3_mode)
      MODE_ADD: begin
        c_next = (sum_add >= 18'(DAY_SECONDS)) ? 17'(sum_add - 18'(DAY_SECONDS))
                                              : sum_add[16:0];
      end
      MODE_SUB: begin
        c_next = (sum_sub >= 18'(DAY_SECONDS)) ? 17'(sum_sub - 18'(DAY_SECONDS))
                                              : sum_sub[16:0];
      end
      MODE_DUR: begin
        secs_next = (s3_db >= s3_da) ? s3_db - s3_da : s3_db + 17'(DAY_SECONDS) - s3_da;
      end
      MODE_TO_TIME: c_next = nmod;
      MODE_TO_SECS: secs_next = s3_da;
      default: begin
        c_next    = '0;
        secs_next = '0;
      end
    endcase
    side_next.r_seconds = secs_next;
    side_next.equal     = (s3_mode == MODE_CMP) && s3_equal;
    side_next.less      = (s3_mode == MODE_CMP) && s3_lt;
    side_next.greater   = (s3_mode == MODE_CMP) && s3_gt;
    side_next.a_valid   = s3_a_ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_c    <= c_next;
      side[4] <= side_next;
      side[5] <= side[4];
      side[6] <= side[5];
      side[7] <= side[6];
      side[8] <= side[7];
    end
  end

  // stages 5..8: hour, minute, second split
  tda_hms u_hms (
    .clk    (clk),
    .en     (en),
    .c      (s4_c),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  assign res.r_hour    = hour;
  assign res.r_minute  = minute;
  assign res.r_second  = second;
  assign res.r_seconds = side[8].r_seconds;
  assign res.equal     = side[8].equal;
  assign res.less      = side[8].less;
  assign res.greater   = side[8].greater;
  assign res.a_valid   = side[8].a_valid;

  a_hms_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.r_hour <= 5'd23) && (res.r_minute <= 6'd59) && (res.r_second <= 6'd59))
    else $error("result time out of range");

  a_secs_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.r_seconds < 17'(DAY_SECONDS))
    else $error("result seconds out of range");

  a_cmp_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(res.equal) + 32'(res.less) + 32'(res.greater)) <= 32'd1)
    else $error("compare flags not exclusive");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the time-of-day arithmetic pipeline.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tda_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS   = 1370;
  localparam int PRESSURE_WORDS = 60;
  localparam int LONG_HOLD      = 100;
  localparam int DRAIN_CYCLES   = 16;
  localparam int STUCK_LIMIT    = 2000;
  localparam int REPORT_CAP     = 200;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_word_t cmd;
  logic      res_valid;
  logic      res_stall;
  res_word_t res;

  res_word_t tod_answers[$];
  int        mismatches = 0;
  int        reported   = 0;
  bit        no_idle    = 0;
  bit        hold_off_request = 0;

  time_of_day_arithmetic dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic res_word_t tod_compute(cmd_word_t w);
    int unsigned raw_a, raw_b, day_a, day_b, span, clock;
    bit          timed;
    res_word_t   r;
    raw_a = w.a_hour * HOUR_SECONDS + w.a_minute * MINUTE_SECONDS + w.a_second;
    raw_b = w.b_hour * HOUR_SECONDS + w.b_minute * MINUTE_SECONDS + w.b_second;
    day_a = raw_a % DAY_SECONDS;
    day_b = raw_b % DAY_SECONDS;
    span  = w.n_seconds % DAY_SECONDS;
    clock = 0;
    timed = 1'b0;
    r = '0;
    r.a_valid = (w.a_hour <= 23 && w.a_minute <= 59 && w.a_second <= 59);
    case (w.mode)
      MODE_ADD: begin
        clock = (day_a + span) % DAY_SECONDS;
        timed = 1'b1;
      end
      MODE_SUB: begin
        clock = (day_a + DAY_SECONDS - span) % DAY_SECONDS;
        timed = 1'b1;
      end
      MODE_TO_TIME: begin
        clock = span;
        timed = 1'b1;
      end
      MODE_DUR: begin
        r.r_seconds = 17'((day_b >= day_a) ? day_b - day_a : day_b + DAY_SECONDS - day_a);
      end
      MODE_CMP: begin
        r.equal   = (w.a_hour == w.b_hour && w.a_minute == w.b_minute &&
                     w.a_second == w.b_second);
        r.less    = (raw_a < raw_b);
        r.greater = (raw_a > raw_b);
      end
      MODE_TO_SECS: begin
        r.r_seconds = 17'(day_a);
      end
      default: ;
    endcase
    if (timed) begin
      r.r_hour   = 5'(clock / HOUR_SECONDS);
      r.r_minute = 6'((clock % HOUR_SECONDS) / MINUTE_SECONDS);
      r.r_second = 6'(clock % MINUTE_SECONDS);
    end
    return r;
  endfunction

  function automatic cmd_word_t tod_word(logic [2:0] mode,
                                         logic [4:0] h0, logic [5:0] m0, logic [5:0] s0,
                                         logic [4:0] h1, logic [5:0] m1, logic [5:0] s1,
                                         logic [30:0] n);
    cmd_word_t w;
    w.mode      = mode;
    w.a_hour    = h0;
    w.a_minute  = m0;
    w.a_second  = s0;
    w.b_hour    = h1;
    w.b_minute  = m1;
    w.b_second  = s1;
    w.n_seconds = n;
    return w;
  endfunction

  function automatic cmd_word_t random_word();
    cmd_word_t w;
    w.mode = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) != 0) begin
      w.a_hour   = 5'($urandom_range(0, 23));
      w.a_minute = 6'($urandom_range(0, 59));
      w.a_second = 6'($urandom_range(0, 59));
    end else begin
      w.a_hour   = 5'($urandom);
      w.a_minute = 6'($urandom);
      w.a_second = 6'($urandom);
    end
    case ($urandom_range(0, 5))
      0: begin
        w.b_hour   = w.a_hour;
        w.b_minute = w.a_minute;
        w.b_second = w.a_second;
      end
      1: begin
        w.b_hour   = 5'($urandom);
        w.b_minute = 6'($urandom);
        w.b_second = 6'($urandom);
      end
      default: begin
        w.b_hour   = 5'($urandom_range(0, 23));
        w.b_minute = 6'($urandom_range(0, 59));
        w.b_second = 6'($urandom_range(0, 59));
      end
    endcase
    case ($urandom_range(0, 3))
      0: w.n_seconds = 31'($urandom_range(0, DAY_SECONDS - 1));
      1: w.n_seconds = 31'($urandom);
      2: w.n_seconds = 31'(DAY_SECONDS * $urandom_range(0, 24855) + $urandom_range(0, 3));
      default: w.n_seconds = 31'h7FFF_FFFF - 31'($urandom_range(0, 200000));
    endcase
    return w;
  endfunction

  // Holds the word until it is taken; valid stays up between back-to-back words.
  task automatic send_word(cmd_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (reported < REPORT_CAP) begin
        reported++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    res_word_t want;
    if (rst === 1'b0) begin
      if (cmd_valid && cmd_stall === 1'b0)
        tod_answers.push_back(tod_compute(cmd));
      if (res_valid === 1'b1 && !res_stall) begin
        if (tod_answers.size() == 0) begin
          mismatches++;
          if (reported < REPORT_CAP) begin
            reported++;
            $display("%0t: no result expected, got %h", $time, res);
          end
        end else begin
          want = tod_answers.pop_front();
          check_field("r_hour",    want.r_hour,    res.r_hour);
          check_field("r_minute",  want.r_minute,  res.r_minute);
          check_field("r_second",  want.r_second,  res.r_second);
          check_field("r_seconds", want.r_seconds, res.r_seconds);
          check_field("equal",     want.equal,     res.equal);
          check_field("less",      want.less,      res.less);
          check_field("greater",   want.greater,   res.greater);
          check_field("a_valid",   want.a_valid,   res.a_valid);
        end
      end
    end
  end

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int hold;
    res_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (res_valid !== 1'b1);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || (cmd_valid && cmd_stall === 1'b0) ||
          (res_valid === 1'b1 && !res_stall))
        stuck = 0;
      else
        stuck++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic test_add_subtract();
    send_word(tod_word(MODE_ADD, 23, 59, 59, 0, 0, 0, 1));
    send_word(tod_word(MODE_ADD, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF));
    send_word(tod_word(MODE_ADD, 12, 30, 30, 5, 5, 5, 0));
    send_word(tod_word(MODE_SUB, 0, 0, 0, 0, 0, 0, 1));
    send_word(tod_word(MODE_SUB, 23, 59, 59, 0, 0, 0, DAY_SECONDS - 1));
    send_word(tod_word(MODE_SUB, 31, 63, 63, 31, 63, 63, 5));
  endtask

  task automatic test_duration();
    send_word(tod_word(MODE_DUR, 10, 0, 0, 9, 0, 0, 0));
    send_word(tod_word(MODE_DUR, 7, 8, 9, 7, 8, 9, 0));
    send_word(tod_word(MODE_DUR, 0, 0, 0, 23, 59, 59, 0));
    send_word(tod_word(MODE_DUR, 0, 0, 0, 31, 63, 63, 31'h7FFF_FFFF));
  endtask

  task automatic test_compare();
    send_word(tod_word(MODE_CMP, 13, 14, 15, 13, 14, 15, 0));
    send_word(tod_word(MODE_CMP, 0, 0, 0, 0, 0, 1, 0));
    send_word(tod_word(MODE_CMP, 23, 59, 59, 23, 59, 58, 0));
    // same second count, different fields
    send_word(tod_word(MODE_CMP, 0, 1, 0, 0, 0, 60, 0));
    send_word(tod_word(MODE_CMP, 31, 63, 63, 23, 59, 59, 0));
  endtask

  task automatic test_conversions();
    send_word(tod_word(MODE_TO_TIME, 0, 0, 0, 0, 0, 0, 0));
    send_word(tod_word(MODE_TO_TIME, 0, 0, 0, 0, 0, 0, DAY_SECONDS - 1));
    send_word(tod_word(MODE_TO_TIME, 0, 0, 0, 0, 0, 0, DAY_SECONDS));
    send_word(tod_word(MODE_TO_TIME, 31, 63, 63, 31, 63, 63, 31'h7FFF_FFFF));
    send_word(tod_word(MODE_TO_SECS, 23, 59, 59, 0, 0, 0, 0));
    send_word(tod_word(MODE_TO_SECS, 31, 63, 63, 0, 0, 0, 0));
    send_word(tod_word(MODE_TO_SECS, 0, 0, 0, 31, 63, 63, 31'h7FFF_FFFF));
  endtask

  task automatic test_unused_modes();
    send_word(tod_word(MODE_SPARE_LO, 31, 63, 63, 31, 63, 63, 31'h7FFF_FFFF));
    send_word(tod_word(MODE_SPARE_HI, 1, 2, 3, 1, 2, 3, 12345));
  endtask

  task automatic test_random();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      no_idle = ((i / 100) % 4 == 3);
      send_word(random_word());
    end
    no_idle = 1'b0;
  endtask

  // Sender keeps offering while results are held back, so the pipe backs up.
  task automatic test_back_pressure();
    no_idle = 1'b1;
    hold_off_request = 1'b1;
    repeat (PRESSURE_WORDS) send_word(random_word());
    no_idle = 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_add_subtract();
    test_duration();
    test_compare();
    test_conversions();
    test_unused_modes();
    test_random();
    test_back_pressure();
    cmd_valid <= 1'b0;
    while (tod_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
